// ===== rtl/core/lfbl_pkg.sv =====
// Shared types, constants and the arrival scaling function of the LED frame brightness limiter.
package lfbl_pkg;

	localparam int unsigned CH_W  = 8;
	localparam int unsigned MC_W  = 10;
	localparam int unsigned SUM_W = 10;
	localparam int unsigned CFG_W = 10;

	localparam logic [CH_W-1:0] MAX_BRIGHTNESS_RESET = 8'd255;
	localparam logic [MC_W-1:0] MAX_COMBINED_RESET   = 10'd765;

	// register indexes on the write port
	localparam logic REG_MAX_BRIGHTNESS = 1'b0;
	localparam logic REG_MAX_COMBINED   = 1'b1;

	// channel selects for the shared divider
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} pixel_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_READ,
		ST_LATCH,
		ST_START,
		ST_WAIT,
		ST_SEND
	} state_t;

	// floor(v * mb / 255): exact for any product of two 8-bit values
	function automatic logic [CH_W-1:0] scale_ch(input logic [CH_W-1:0] v,
	                                             input logic [CH_W-1:0] mb);
		logic [15:0] p;
		logic [16:0] t;
		p = v * mb;
		t = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
		return t[15:8];
	endfunction

endpackage

// ===== rtl/core/lfbl_store.sv =====
// Frame store: single-port-write, registered-read pixel memory.
module lfbl_store #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  lfbl_pkg::pixel_t wr_data,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output lfbl_pkg::pixel_t rd_data
);
	import lfbl_pkg::*;

	pixel_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/lfbl_divider.sv =====
// Iterative divider: floor(chan * mult / divisor), one quotient bit per cycle.
module lfbl_divider (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [lfbl_pkg::CH_W-1:0] chan,
	input  logic [lfbl_pkg::MC_W-1:0] mult,
	input  logic [lfbl_pkg::MC_W-1:0] divisor,
	output lfbl_pkg::div_status_t status,
	output logic [lfbl_pkg::CH_W-1:0] quotient
);
	import lfbl_pkg::*;

	localparam int unsigned PROD_W = CH_W + MC_W;

	logic [MC_W-1:0]   rem_q;
	logic [CH_W-1:0]   dvd_q;
	logic [CH_W-1:0]   quo_q;
	logic [3:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [PROD_W-1:0] prod;
	logic [MC_W:0]     trial;
	logic              take;

	assign prod  = chan * mult;
	assign trial = {rem_q, dvd_q[CH_W-1]};
	assign take  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 4'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'(CH_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient is known to fit CH_W bits, so the high part of the product starts below divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= prod[PROD_W-1:CH_W];
			dvd_q <= prod[CH_W-1:0];
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? MC_W'(trial - {1'b0, divisor}) : trial[MC_W-1:0];
			dvd_q <= {dvd_q[CH_W-2:0], 1'b0};
			quo_q <= {quo_q[CH_W-2:0], take};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;

endmodule

// ===== rtl/core/led_frame_brightness_limiter.sv =====
// A frame is emitted once its last pixel is taken.
// Loading: one pixel per cycle, scaled on arrival and written to the frame store.
// Emission: store read, latch and send for each pixel when unlimited; when limited, the
// shared divider scales the three channels in turn between the latch and the send.
// Input stalls during emission. Reset: fill count and peak clear, registers to 255 and 765;
// the store is not cleared.
module led_frame_brightness_limiter #(
	parameter int unsigned FRAME_PIXELS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [lfbl_pkg::CH_W-1:0] red,
	input  logic [lfbl_pkg::CH_W-1:0] green,
	input  logic [lfbl_pkg::CH_W-1:0] blue,
	input  logic                      last_pixel,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [lfbl_pkg::CH_W-1:0] out_red,
	output logic [lfbl_pkg::CH_W-1:0] out_green,
	output logic [lfbl_pkg::CH_W-1:0] out_blue,
	output logic                      end_of_frame,
	output logic                      limited,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [lfbl_pkg::CFG_W-1:0] cfg_data
);
	import lfbl_pkg::*;

	localparam int unsigned AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
	localparam int unsigned CW = $clog2(FRAME_PIXELS + 1);

	state_t          state_q, state_d;
	logic [CH_W-1:0] max_brightness_q;
	logic [MC_W-1:0] max_combined_q;
	logic [MC_W-1:0] mc_lat_q;
	logic [CW-1:0]   fill_q;
	logic [SUM_W-1:0] peak_q;
	logic [AW-1:0]   emit_idx_q;
	logic [1:0]      ch_q;
	logic            lim_q;
	logic            eof_q;
	pixel_t          pix_q;
	pixel_t          res_q;

	pixel_t          scaled;
	pixel_t          rd_data;
	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] peak_new;
	logic            in_acc;
	logic            out_acc;
	logic            frame_done;
	logic            rd_en;
	logic            div_start;
	logic [CH_W-1:0] div_chan;
	logic [CH_W-1:0] quotient;
	div_status_t     dst;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	assign scaled.r = scale_ch(red, max_brightness_q);
	assign scaled.g = scale_ch(green, max_brightness_q);
	assign scaled.b = scale_ch(blue, max_brightness_q);
	assign sum      = SUM_W'(scaled.r) + SUM_W'(scaled.g) + SUM_W'(scaled.b);
	assign peak_new = (sum > peak_q) ? sum : peak_q;
	assign frame_done = last_pixel || (fill_q + CW'(1) == CW'(FRAME_PIXELS));

	lfbl_store #(
		.DEPTH (FRAME_PIXELS),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (in_acc),
		.wr_addr (fill_q[AW-1:0]),
		.wr_data (scaled),
		.rd_en   (rd_en),
		.rd_addr (emit_idx_q),
		.rd_data (rd_data)
	);

	always_comb begin
		case (ch_q)
			CH_RED:   div_chan = pix_q.r;
			CH_GREEN: div_chan = pix_q.g;
			default:  div_chan = pix_q.b;
		endcase
	end

	lfbl_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.chan     (div_chan),
		.mult     (mc_lat_q),
		.divisor  (peak_q),
		.status   (dst),
		.quotient (quotient)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:  if (in_acc && frame_done) state_d = ST_READ;
			ST_READ:  state_d = ST_LATCH;
			ST_LATCH: state_d = lim_q ? ST_START : ST_SEND;
			ST_START: state_d = ST_WAIT;
			ST_WAIT: begin
				if (dst.done) state_d = (ch_q == CH_BLUE) ? ST_SEND : ST_START;
			end
			ST_SEND: begin
				if (out_acc) state_d = eof_q ? ST_LOAD : ST_READ;
			end
			default:  state_d = ST_LOAD;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		rd_en     = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_LOAD:  in_stall  = 1'b0;
			ST_READ:  rd_en     = 1'b1;
			ST_LATCH: ;
			ST_START: div_start = 1'b1;
			ST_WAIT:  ;
			ST_SEND:  out_valid = 1'b1;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_LOAD;
			max_brightness_q <= MAX_BRIGHTNESS_RESET;
			max_combined_q   <= MAX_COMBINED_RESET;
			fill_q           <= '0;
			peak_q           <= '0;
			emit_idx_q       <= '0;
			ch_q             <= CH_RED;
			lim_q            <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAX_BRIGHTNESS: max_brightness_q <= cfg_data[CH_W-1:0];
					REG_MAX_COMBINED:   max_combined_q   <= cfg_data[MC_W-1:0];
					default:            ;
				endcase
			end
			if (in_acc) begin
				fill_q <= fill_q + CW'(1);
				peak_q <= peak_new;
				if (frame_done) begin
					emit_idx_q <= '0;
					lim_q      <= peak_new > max_combined_q;
				end
			end
			if (state_q == ST_LATCH) ch_q <= CH_RED;
			if (state_q == ST_WAIT && dst.done) ch_q <= ch_q + 2'd1;
			if (out_acc) begin
				if (eof_q) begin
					fill_q <= '0;
					peak_q <= '0;
				end else begin
					emit_idx_q <= emit_idx_q + AW'(1);
				end
			end
		end
	end

	// payload: hold the limit for the whole emission, capture pixels and results
	always_ff @(posedge clk) begin
		if (in_acc && frame_done) mc_lat_q <= max_combined_q;
		if (state_q == ST_LATCH) begin
			pix_q <= rd_data;
			res_q <= rd_data;
			eof_q <= CW'(emit_idx_q) == fill_q - CW'(1);
		end
		if (state_q == ST_WAIT && dst.done) begin
			case (ch_q)
				CH_RED:   res_q.r <= quotient;
				CH_GREEN: res_q.g <= quotient;
				default:  res_q.b <= quotient;
			endcase
		end
	end

	assign out_red      = res_q.r;
	assign out_green    = res_q.g;
	assign out_blue     = res_q.b;
	assign end_of_frame = eof_q;
	assign limited      = lim_q;

	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |-> fill_q < CW'(FRAME_PIXELS))
		else $error("fill count reached frame size while loading");

	a_div_idle_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_START |-> !dst.busy && !dst.done)
		else $error("divider started while still busy");

	a_limit_not_above: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && limited |->
			out_red <= pix_q.r && out_green <= pix_q.g && out_blue <= pix_q.b)
		else $error("limited channel exceeds stored channel");

	a_div_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		dst.done |-> state_q == ST_WAIT)
		else $error("divider finished outside of wait");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the LED frame brightness limiter: directed table, then random frames.
`timescale 1ns / 100ps

module tb_top;
	import lfbl_pkg::*;

	localparam int FRAME_LEN = 64;
	localparam int SETTLE_CYC = 8;
	localparam int HOLD_CYC = 400;
	localparam int PHASE_ITEMS = 10;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		logic            eof;
		logic            lim;
	} beat_t;

	typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t       kind;
		logic            reg_idx;
		logic [CFG_W-1:0] data;
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		logic            last;
		logic            typed;
		beat_t           want;
	} drow_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [CH_W-1:0]  red = '0;
	logic [CH_W-1:0]  green = '0;
	logic [CH_W-1:0]  blue = '0;
	logic             last_pixel = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [CH_W-1:0]  out_red;
	logic [CH_W-1:0]  out_green;
	logic [CH_W-1:0]  out_blue;
	logic             end_of_frame;
	logic             limited;
	logic             cfg_we = 1'b0;
	logic             cfg_index = REG_MAX_BRIGHTNESS;
	logic [CFG_W-1:0] cfg_data = '0;

	// predictor state
	pixel_t          frame_px[$];
	logic [SUM_W-1:0] frame_peak = '0;
	logic [CH_W-1:0] bright_lvl = MAX_BRIGHTNESS_RESET;
	logic [MC_W-1:0] combined_cap = MAX_COMBINED_RESET;

	beat_t       pending_beats[$];
	drow_t       dir_rows[$];
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	bit          hold_request = 1'b0;
	int          mismatches = 0;

	led_frame_brightness_limiter #(.FRAME_PIXELS(FRAME_LEN)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.red(red), .green(green), .blue(blue), .last_pixel(last_pixel),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue),
		.end_of_frame(end_of_frame), .limited(limited),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [CH_W-1:0] scaled(input logic [CH_W-1:0] v);
		logic [15:0] prod;
		prod = v * bright_lvl;
		return 8'(prod / 16'd255);
	endfunction

	function automatic logic [CH_W-1:0] capped(input logic [CH_W-1:0] c);
		logic [17:0] prod;
		prod = c * combined_cap;
		return 8'(prod / {8'd0, frame_peak});
	endfunction

	// Scale the pixel into the frame; on frame end, produce every beat of the frame.
	function automatic void absorb_pixel(input logic [CH_W-1:0] r, g, b, input logic last,
	                                     output beat_t made[$]);
		pixel_t           p;
		logic [SUM_W-1:0] s;
		logic             lim;
		beat_t            e;
		made = {};
		p.r = scaled(r);
		p.g = scaled(g);
		p.b = scaled(b);
		s = {2'b0, p.r} + {2'b0, p.g} + {2'b0, p.b};
		frame_px.push_back(p);
		if (s > frame_peak)
			frame_peak = s;
		if (last || frame_px.size() == FRAME_LEN) begin
			lim = frame_peak > combined_cap;
			foreach (frame_px[k]) begin
				e.r = lim ? capped(frame_px[k].r) : frame_px[k].r;
				e.g = lim ? capped(frame_px[k].g) : frame_px[k].g;
				e.b = lim ? capped(frame_px[k].b) : frame_px[k].b;
				e.eof = (k == frame_px.size() - 1);
				e.lim = lim;
				made.push_back(e);
			end
			frame_px.delete();
			frame_peak = '0;
		end
	endfunction

	function automatic void cmp_field(input string name, input logic [CH_W-1:0] want,
	                                  input logic [CH_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function automatic logic [CH_W-1:0] rand_chan();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic drow_t pix(input logic [CH_W-1:0] r, g, b, input logic last);
		drow_t d;
		d = '0;
		d.kind = ROW_PIXEL;
		d.r = r;
		d.g = g;
		d.b = b;
		d.last = last;
		return d;
	endfunction

	function automatic drow_t pix_exp(input logic [CH_W-1:0] r, g, b, input beat_t want);
		drow_t d;
		d = pix(r, g, b, 1'b1);
		d.typed = 1'b1;
		d.want = want;
		return d;
	endfunction

	function automatic drow_t reg_row(input logic idx, input logic [CFG_W-1:0] data);
		drow_t d;
		d = '0;
		d.kind = ROW_REG;
		d.reg_idx = idx;
		d.data = data;
		return d;
	endfunction

	task automatic send_pixel(input logic [CH_W-1:0] r, g, b, input logic last,
	                          input logic typed, input beat_t want);
		beat_t made[$];
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		last_pixel <= last;
		do @(posedge clk); while (in_stall);
		absorb_pixel(r, g, b, last, made);
		if (typed)
			pending_beats.push_back(want);
		else
			foreach (made[k]) pending_beats.push_back(made[k]);
	endtask

	// Hold the input until every expected beat is out and the block has settled.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MAX_BRIGHTNESS)
			bright_lvl = data[CH_W-1:0];
		else
			combined_cap = data;
	endtask

	task automatic send_frame(input int len, input logic mark_last);
		for (int k = 0; k < len; k++)
			send_pixel(rand_chan(), rand_chan(), rand_chan(), mark_last && (k == len - 1),
			           1'b0, '0);
	endtask

	// receiver: check accepted beats, stall at random or for a long hold
	initial begin : receiver
		int hold_left;
		beat_t want;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_beats.size() == 0) begin
					$display("%0t: unexpected beat r=%0d g=%0d b=%0d eof=%0b lim=%0b", $time,
					         out_red, out_green, out_blue, end_of_frame, limited);
					mismatches++;
				end else begin
					want = pending_beats.pop_front();
					cmp_field("out_red", want.r, out_red);
					cmp_field("out_green", want.g, out_green);
					cmp_field("out_blue", want.b, out_blue);
					cmp_field("end_of_frame", 8'(want.eof), 8'(end_of_frame));
					cmp_field("limited", 8'(want.lim), 8'(limited));
				end
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYC;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	initial begin
		#800000;
		$display("** led_frame_brightness_limiter: FAILED **");
		$finish;
	end

	initial begin : stimulus
		int sent;
		int len;
		logic [CH_W-1:0] mb;
		logic [MC_W-1:0] mc;

		// reset defaults, bit patterns, equality with the cap, zero cap, zero brightness
		dir_rows.push_back(pix_exp(8'd255, 8'd255, 8'd255, '{8'd255, 8'd255, 8'd255, 1'b1, 1'b0}));
		dir_rows.push_back(pix_exp(8'd0, 8'd0, 8'd0, '{8'd0, 8'd0, 8'd0, 1'b1, 1'b0}));
		dir_rows.push_back(pix(8'd170, 8'd85, 8'd1, 1'b0));
		dir_rows.push_back(pix(8'd85, 8'd170, 8'd254, 1'b0));
		dir_rows.push_back(pix(8'd128, 8'd64, 8'd32, 1'b1));
		dir_rows.push_back(reg_row(REG_MAX_COMBINED, 10'd255));
		dir_rows.push_back(pix_exp(8'd255, 8'd255, 8'd255, '{8'd85, 8'd85, 8'd85, 1'b1, 1'b1}));
		dir_rows.push_back(pix(8'd10, 8'd20, 8'd30, 1'b0));
		dir_rows.push_back(pix(8'd200, 8'd100, 8'd0, 1'b1));
		dir_rows.push_back(pix_exp(8'd85, 8'd85, 8'd85, '{8'd85, 8'd85, 8'd85, 1'b1, 1'b0}));
		dir_rows.push_back(reg_row(REG_MAX_COMBINED, 10'd0));
		dir_rows.push_back(pix_exp(8'd255, 8'd0, 8'd0, '{8'd0, 8'd0, 8'd0, 1'b1, 1'b1}));
		dir_rows.push_back(pix_exp(8'd0, 8'd0, 8'd0, '{8'd0, 8'd0, 8'd0, 1'b1, 1'b0}));
		dir_rows.push_back(reg_row(REG_MAX_BRIGHTNESS, 10'h300));
		dir_rows.push_back(pix_exp(8'd255, 8'd255, 8'd255, '{8'd0, 8'd0, 8'd0, 1'b1, 1'b0}));
		dir_rows.push_back(reg_row(REG_MAX_BRIGHTNESS, 10'd128));
		dir_rows.push_back(reg_row(REG_MAX_COMBINED, 10'd1023));
		dir_rows.push_back(pix(8'd255, 8'd255, 8'd255, 1'b0));
		dir_rows.push_back(pix(8'd1, 8'd2, 8'd3, 1'b1));
		dir_rows.push_back(reg_row(REG_MAX_COMBINED, 10'd300));
		dir_rows.push_back(pix(8'd255, 8'd0, 8'd255, 1'b0));
		dir_rows.push_back(pix(8'd0, 8'd255, 8'd0, 1'b0));
		dir_rows.push_back(pix(8'd254, 8'd127, 8'd64, 1'b1));

		send_idle_pct = 10;
		recv_idle_pct = 76;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_REG) begin
				drain();
				write_reg(dir_rows[i].reg_idx, dir_rows[i].data);
			end else begin
				send_pixel(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b, dir_rows[i].last,
				           dir_rows[i].typed, dir_rows[i].want);
			end
		end

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			case (ph / 2)
				0: begin
					send_idle_pct = 10;
					recv_idle_pct = 76;
				end
				1: begin
					send_idle_pct = 76;
					recv_idle_pct = 10;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case ($urandom_range(3))
				0: mb = 8'd255;
				1: mb = 8'($urandom_range(255));
				default: mb = 8'($urandom_range(255, 96));
			endcase
			case ($urandom_range(3))
				0: mc = 10'($urandom_range(1023, 700));
				1: mc = 10'($urandom_range(765));
				default: mc = 10'($urandom_range(400, 100));
			endcase
			write_reg(REG_MAX_BRIGHTNESS, {2'($urandom_range(3)), mb});
			write_reg(REG_MAX_COMBINED, mc);

			sent = 0;
			if (ph == 1) begin
				// long receiver hold while a full unmarked frame and more pixels pile in
				hold_request = 1'b1;
				send_frame(FRAME_LEN, 1'b0);
				sent = FRAME_LEN;
			end else if (ph == 4) begin
				send_frame(FRAME_LEN, 1'b1);
				sent = FRAME_LEN;
			end
			while (sent < PHASE_ITEMS || ph == 1 && sent < FRAME_LEN + 12) begin
				len = ($urandom_range(5) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
				send_frame(len, 1'b1);
				sent += len;
			end
		end

		in_valid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("** led_frame_brightness_limiter: PASSED **");
		else
			$display("** led_frame_brightness_limiter: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/lfbl_pkg.sv
rtl/core/lfbl_store.sv
rtl/core/lfbl_divider.sv
rtl/core/led_frame_brightness_limiter.sv
test/tb_top.sv
